// ===== design/branch_and_cr_logic_unit_macros.svh =====
// assertion macros for the branch and cr logic unit
// expects clk_i and rst_ni in the scope of each use
`ifndef BRANCH_AND_CR_LOGIC_UNIT_MACROS_SVH
`define BRANCH_AND_CR_LOGIC_UNIT_MACROS_SVH

// property checked on every rising edge outside reset
`define BCR_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("bcr assertion failed");

// same check with a caller-supplied message
`define BCR_ASSERT_MSG(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

`endif

// ===== design/bcr_pkg.sv =====
// shared types and constants for the branch and cr logic unit
// no dependencies
package bcr_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned ActionW = 3;
  localparam int unsigned InW     = ActionW + 5 * WordW;     // 163 payload bits
  localparam int unsigned InTdW   = ((InW + 7) / 8) * 8;     // 168
  localparam int unsigned OutW    = 4 * WordW + 1;           // 129 payload bits
  localparam int unsigned OutTdW  = ((OutW + 7) / 8) * 8;    // 136

  localparam logic [WordW-1:0] SeqStep    = 32'd4;
  localparam logic [WordW-1:0] TargetMask = 32'hffff_fffc;

  typedef enum logic [ActionW-1:0] {
    ACT_BCCTR = 3'd0,
    ACT_BCLR  = 3'd1,
    ACT_MCRF  = 3'd2,
    ACT_CROR  = 3'd3,
    ACT_CRNOR = 3'd4,
    ACT_CRXOR = 3'd5,
    ACT_ISYNC = 3'd6
  } bcr_action_e;

  // input word, first field in the highest bits
  typedef struct packed {
    logic [WordW-1:0] pc;
    logic [WordW-1:0] count_reg_in;
    logic [WordW-1:0] link_reg_in;
    logic [WordW-1:0] cond_reg_in;
    logic [WordW-1:0] instruction;
    bcr_action_e      action;
  } bcr_item_t;

  // result word, first field in the highest bits
  typedef struct packed {
    logic [WordW-1:0] next_pc;
    logic             taken;
    logic [WordW-1:0] count_reg_out;
    logic [WordW-1:0] link_reg_out;
    logic [WordW-1:0] cond_reg_out;
  } bcr_res_t;

endpackage

// ===== design/bcr_exec.sv =====
// combinational execute logic: branch condition, ctr/lr update, cr logical ops
// depends on bcr_pkg
module bcr_exec (
  input  bcr_pkg::bcr_item_t item_i,
  output bcr_pkg::bcr_res_t  res_o
);

  logic [4:0]  bo;
  logic [4:0]  bi;
  logic [4:0]  bb;
  logic        lk;
  logic [31:0] cr;
  logic [31:0] seq;
  logic [31:0] ctr_dec;
  logic        bit_a;
  logic        bit_b;
  logic        cond_ok;
  logic        ctr_ok;
  logic [4:0]  src_lo;
  logic [3:0]  src_field;
  logic [31:0] mcrf_cr;
  logic [31:0] setbit_cr;
  logic        set_val;

  assign bo      = item_i.instruction[25:21];
  assign bi      = item_i.instruction[20:16];
  assign bb      = item_i.instruction[15:11];
  assign lk      = item_i.instruction[0];
  assign cr      = item_i.cond_reg_in;
  assign seq     = item_i.pc + bcr_pkg::SeqStep;
  assign ctr_dec = item_i.count_reg_in - 32'd1;

  // cr bits are numbered from the msb
  assign bit_a   = cr[5'd31 - bi];
  assign bit_b   = cr[5'd31 - bb];
  assign cond_ok = bo[4] | (bit_a == bo[3]);
  // bclr tests the decremented ctr
  assign ctr_ok  = bo[2] | ((ctr_dec != 32'd0) != bo[1]);

  // mcrf: 4-bit field copy, field 0 is the top nibble
  assign src_lo    = 5'd28 - {bi[4:2], 2'b00};
  assign src_field = cr[src_lo +: 4];

  always_comb begin
    mcrf_cr = cr;
    for (int f = 0; f < 8; f++) begin
      if (bo[4:2] == 3'(f)) begin
        mcrf_cr[28 - 4*f +: 4] = src_field;
      end
    end
  end

  always_comb begin
    unique case (item_i.action)
      bcr_pkg::ACT_CROR:  set_val = bit_a | bit_b;
      bcr_pkg::ACT_CRNOR: set_val = ~(bit_a | bit_b);
      bcr_pkg::ACT_CRXOR: set_val = bit_a ^ bit_b;
      default:            set_val = 1'b0;
    endcase
    setbit_cr = cr;
    setbit_cr[5'd31 - bo] = set_val;
  end

  always_comb begin
    res_o.cond_reg_out  = cr;
    res_o.link_reg_out  = item_i.link_reg_in;
    res_o.count_reg_out = item_i.count_reg_in;
    res_o.taken         = 1'b0;
    res_o.next_pc       = seq;
    unique case (item_i.action)
      bcr_pkg::ACT_BCCTR: begin
        res_o.taken = cond_ok;
        if (cond_ok) begin
          res_o.next_pc = item_i.count_reg_in & bcr_pkg::TargetMask;
        end
        if (lk) begin
          res_o.link_reg_out = seq;
        end
      end
      bcr_pkg::ACT_BCLR: begin
        if (!bo[2]) begin
          res_o.count_reg_out = ctr_dec;
        end
        res_o.taken = cond_ok & ctr_ok;
        if (cond_ok && ctr_ok) begin
          res_o.next_pc = item_i.link_reg_in & bcr_pkg::TargetMask;
        end
        if (lk) begin
          res_o.link_reg_out = seq;
        end
      end
      bcr_pkg::ACT_MCRF: begin
        res_o.cond_reg_out = mcrf_cr;
      end
      bcr_pkg::ACT_CROR, bcr_pkg::ACT_CRNOR, bcr_pkg::ACT_CRXOR: begin
        res_o.cond_reg_out = setbit_cr;
      end
      default: begin
        // isync and the unused code change nothing
      end
    endcase
  end

endmodule

// ===== design/bcr_out_reg.sv =====
// result register with valid/ready handshake toward the master side
// depends on bcr_pkg
module bcr_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  bcr_pkg::bcr_res_t data_i,
  output logic              valid_o,
  input  logic              ready_i,
  output bcr_pkg::bcr_res_t data_o
);

  logic              valid_q;
  logic              valid_d;
  bcr_pkg::bcr_res_t data_q;

  assign ready_o = !valid_q || ready_i;
  assign valid_d = ready_o ? valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== design/branch_and_cr_logic_unit.sv =====
// top level of the branch and cr logic unit: input register, execute logic,
// result register; depends on bcr_pkg, bcr_exec, bcr_out_reg and the macro header
//
// usage
//  - slave channel s_axis_*: one word per instruction carrying the action code,
//    the instruction word and the current cr, lr, ctr and pc
//  - master channel m_axis_*: one word per instruction with the new cr, lr, ctr,
//    the taken flag and the next pc
//  - a word is moved at a rising edge with tvalid and tready both high
//  - path: an accepted word waits in the input register; its result is loaded into
//    the result register and offered from there on the master side
//  - throughput: one instruction per cycle while m_axis_tready is high; the execute
//    logic is a single combinational pass between the two registers, no loop, no shared unit
//  - stall: when m_axis_tready is low the result register holds its word; one
//    more instruction may sit in the input register, after which s_axis_tready
//    drops until the master side drains
//  - reset (rst_ni low, asynchronous): both valid flags clear, nothing is
//    offered and s_axis_tready goes high
//  - no configuration and no state carried between instructions
`include "branch_and_cr_logic_unit_macros.svh"

module branch_and_cr_logic_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // action[2:0], instruction[34:3], cond_reg_in[66:35], link_reg_in[98:67],
  // count_reg_in[130:99], pc[162:131], zero fill [167:163]
  input  logic [bcr_pkg::InTdW-1:0]  s_axis_tdata,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // cond_reg_out[31:0], link_reg_out[63:32], count_reg_out[95:64], taken[96],
  // next_pc[128:97], zero fill [135:129]
  output logic [bcr_pkg::OutTdW-1:0] m_axis_tdata,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready
);

  // input register
  logic               in_valid_q;
  logic               in_valid_d;
  bcr_pkg::bcr_item_t in_q;
  logic               s_fire;

  // execute result and result register
  bcr_pkg::bcr_res_t  exec_res;
  bcr_pkg::bcr_res_t  out_data;
  logic               out_ready;
  logic               out_load;

  // helpers for the checks below
  logic               in_is_branch;
  logic               lr_ctr_kept;

  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign out_load      = in_valid_q && out_ready;
  // room in the input register when empty or when its word moves on
  assign s_axis_tready = !in_valid_q || out_ready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_fire) begin
      in_valid_d = 1'b1;
    end else if (out_load) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      in_q <= bcr_pkg::bcr_item_t'(s_axis_tdata[bcr_pkg::InW-1:0]);
    end
  end

  bcr_exec u_exec (
    .item_i (in_q),
    .res_o  (exec_res)
  );

  bcr_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_q),
    .ready_o (out_ready),
    .data_i  (exec_res),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .data_o  (out_data)
  );

  assign m_axis_tdata = {(bcr_pkg::OutTdW - bcr_pkg::OutW)'(0), out_data};

  assign in_is_branch = (in_q.action == bcr_pkg::ACT_BCCTR) ||
                        (in_q.action == bcr_pkg::ACT_BCLR);
  assign lr_ctr_kept  = (exec_res.link_reg_out == in_q.link_reg_in) &&
                        (exec_res.count_reg_out == in_q.count_reg_in);

  // only branches may report taken
  `BCR_ASSERT_MSG(a_taken_only_branch, (out_load && exec_res.taken) |-> in_is_branch, "taken on a non-branch")
  // non-branches leave lr and ctr alone
  `BCR_ASSERT(a_nonbranch_keeps_lr_ctr, (out_load && !in_is_branch) |-> lr_ctr_kept)
  // a taken target is word aligned
  `BCR_ASSERT(a_target_aligned, (out_load && exec_res.taken) |-> (exec_res.next_pc[1:0] == 2'b00))
  // an accepted word is held in the input register next cycle
  `BCR_ASSERT(a_accept_fills_in_reg, s_fire |=> in_valid_q)
  // back pressure only with a word waiting
  `BCR_ASSERT(a_stall_needs_word, !s_axis_tready |-> (in_valid_q && m_axis_tvalid))

endmodule
